### hdl/pklc_pkg.sv
// Package of the pair keyed LRU cache: sizes, widths and the command and
// status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package pklc_pkg;

    localparam int CAPACITY = 16;
    localparam int EVICT    = 4;
    localparam int ID_BITS  = 32;

    localparam int IN_ID_W = 32;
    localparam int AXIS_W  = 64;
    localparam int KEY_W   = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int REC_W   = IDX_W;
    localparam int PAY_W   = 3 * AXIS_W;
    localparam int KREC_W  = 2 * KEY_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    typedef struct packed {
        logic load_req;
        logic evict;
        logic scan_step;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_store;
        logic full;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/pklc_req_if.sv
// Request channel of the pair keyed LRU cache: handshake and access fields.
// Depends on pklc_pkg.
`default_nettype none

interface pklc_req_if import pklc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [IN_ID_W-1:0] self_id;
    logic [IN_ID_W-1:0] other_id;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;

    modport source (output valid, command, self_id, other_id, axis_x, axis_y, axis_z,
                    input ready);
    modport sink   (input valid, command, self_id, other_id, axis_x, axis_y, axis_z,
                    output ready);
endinterface

`default_nettype wire

### hdl/pklc_rsp_if.sv
// Response channel of the pair keyed LRU cache: handshake and result fields.
// Depends on pklc_pkg.
`default_nettype none

interface pklc_rsp_if import pklc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [AXIS_W-1:0] hit_axis_x;
    logic [AXIS_W-1:0] hit_axis_y;
    logic [AXIS_W-1:0] hit_axis_z;

    modport source (output valid, found, hit_axis_x, hit_axis_y, hit_axis_z, input ready);
    modport sink   (input valid, found, hit_axis_x, hit_axis_y, hit_axis_z, output ready);
endinterface

`default_nettype wire

### hdl/pklc_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module pklc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/pklc_ctrl.sv
// Controller of the pair keyed LRU cache: sequences accept, eviction, key scan,
// table update and result transfer. Depends on pklc_pkg.
`default_nettype none

module pklc_ctrl import pklc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVICT  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict = i_sts.is_store && i_sts.full;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/pklc_dp.sv
// Datapath of the pair keyed LRU cache: request registers, valid and recency
// flops, key and payload memories, scan logic and output register.
// Depends on pklc_pkg and pklc_ram.
`default_nettype none

module pklc_dp import pklc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic               i_command,
    input  wire logic [IN_ID_W-1:0] i_self_id,
    input  wire logic [IN_ID_W-1:0] i_other_id,
    input  wire logic [AXIS_W-1:0]  i_axis_x,
    input  wire logic [AXIS_W-1:0]  i_axis_y,
    input  wire logic [AXIS_W-1:0]  i_axis_z,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_found,
    output logic      [AXIS_W-1:0]  o_hit_axis_x,
    output logic      [AXIS_W-1:0]  o_hit_axis_y,
    output logic      [AXIS_W-1:0]  o_hit_axis_z
);

    logic               r_is_store;
    logic [KEY_W-1:0]   r_lo;
    logic [KEY_W-1:0]   r_hi;
    logic [PAY_W-1:0]   r_axes;

    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [REC_W-1:0]    r_rec [CAPACITY];
    logic [REC_W-1:0]    n_rec [CAPACITY];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic [CNT_W-1:0] r_scan_cnt;
    logic             r_cmp_en;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_slot;

    logic             r_out_valid;
    logic             r_found;
    logic [PAY_W-1:0] r_out_axes;

    logic [KEY_W-1:0]  id_a;
    logic [KEY_W-1:0]  id_b;
    logic              scan_issue;
    logic [IDX_W-1:0]  scan_addr;
    logic [KREC_W-1:0] key_rdata;
    logic              key_match;
    logic [IDX_W-1:0]  free_idx;
    logic [CNT_W-1:0]  keep;
    logic [REC_W-1:0]  touch_rank;
    logic              key_we;
    logic              pay_we;
    logic              pay_re;
    logic [IDX_W-1:0]  pay_waddr;
    logic [PAY_W-1:0]  pay_rdata;

    assign id_a       = i_self_id[KEY_W-1:0];
    assign id_b       = i_other_id[KEY_W-1:0];
    assign scan_issue = i_cmd.scan_step && (r_scan_cnt != CNT_W'(CAPACITY));
    assign scan_addr  = r_scan_cnt[IDX_W-1:0];
    assign key_match  = r_cmp_en && r_valid[r_cmp_idx] && (key_rdata == {r_lo, r_hi});

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_rec      = r_rec;
        n_count    = r_count;
        keep       = '0;
        touch_rank = r_rec[r_slot];
        key_we     = 1'b0;
        pay_we     = 1'b0;
        pay_re     = 1'b0;
        pay_waddr  = r_slot;
        if (i_cmd.evict) begin
            if (32'(r_count) < EVICT) begin
                n_valid = '0;
                n_count = '0;
            end else begin
                keep = r_count - CNT_W'(EVICT);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i] && (CNT_W'(r_rec[i]) >= keep)) begin
                        n_valid[i] = 1'b0;
                    end
                end
                n_count = keep;
            end
        end
        if (i_cmd.update) begin
            if (r_hit) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i] && (r_rec[i] < touch_rank)) begin
                        n_rec[i] = r_rec[i] + 1'b1;
                    end
                end
                n_rec[r_slot] = '0;
                pay_re        = !r_is_store;
                pay_we        = r_is_store;
            end else if (r_is_store) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i]) begin
                        n_rec[i] = r_rec[i] + 1'b1;
                    end
                end
                n_valid[free_idx] = 1'b1;
                n_rec[free_idx]   = '0;
                n_count           = r_count + 1'b1;
                key_we            = 1'b1;
                pay_we            = 1'b1;
                pay_waddr         = free_idx;
            end
        end
    end

    pklc_ram #(
        .WIDTH(KREC_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(free_idx),
        .i_wdata({r_lo, r_hi}),
        .i_re   (scan_issue),
        .i_raddr(scan_addr),
        .o_rdata(key_rdata)
    );

    pklc_ram #(
        .WIDTH(PAY_W),
        .DEPTH(CAPACITY)
    ) u_pay_ram (
        .i_clk  (i_clk),
        .i_we   (pay_we),
        .i_waddr(pay_waddr),
        .i_wdata(r_axes),
        .i_re   (pay_re),
        .i_raddr(r_slot),
        .o_rdata(pay_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_lo   <= (id_a < id_b) ? id_a : id_b;
            r_hi   <= (id_a < id_b) ? id_b : id_a;
            r_axes <= {i_axis_x, i_axis_y, i_axis_z};
        end
        if (key_match && i_cmd.scan_step) begin
            r_slot <= r_cmp_idx;
        end
        if (scan_issue) begin
            r_cmp_idx <= scan_addr;
        end
        r_rec <= n_rec;
        if (i_cmd.load_out) begin
            r_found    <= !r_is_store && r_hit;
            r_out_axes <= (!r_is_store && r_hit) ? pay_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_store  <= CMD_LOOKUP;
            r_valid     <= '0;
            r_count     <= '0;
            r_scan_cnt  <= '0;
            r_cmp_en    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            if (i_cmd.load_req) begin
                r_is_store <= (i_command == CMD_STORE);
                r_scan_cnt <= '0;
                r_cmp_en   <= 1'b0;
                r_hit      <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_en <= scan_issue;
                if (scan_issue) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                if (key_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_store  = r_is_store;
    assign o_sts.full      = (r_count >= CNT_W'(CAPACITY));
    assign o_sts.scan_done = (r_scan_cnt == CNT_W'(CAPACITY));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_hit_axis_x = r_out_axes[3*AXIS_W-1:2*AXIS_W];
    assign o_hit_axis_y = r_out_axes[2*AXIS_W-1:AXIS_W];
    assign o_hit_axis_z = r_out_axes[AXIS_W-1:0];

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_valid))
        else $error("Entry count differs from the number of valid entries.");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_valid[r_slot])
        else $error("Recorded hit points at an invalid entry.");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_is_store && !r_hit) |-> !(&r_valid))
        else $error("Insert found no free entry.");

    a_store_leaves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_is_store) |=> (r_count != '0))
        else $error("Table is empty after a store.");

endmodule

`default_nettype wire

### hdl/pair_keyed_lru_cache.sv
// Top level of the pair keyed LRU cache: joins controller and datapath to the
// request and response channels. Depends on pklc_pkg, the channel interfaces,
// pklc_ctrl and pklc_dp.
//
// The cache holds CAPACITY entries keyed by the sorted pair of two ids and
// serves one access at a time. After the request transfer the access passes
// through an eviction step, a key scan that reads the keys from the key memory
// one entry per cycle through its registered read port, an update step and
// the load of the output register. A new request is taken once the previous
// one has its result in the output register, even if that result has not been
// transferred yet; a stalled response then holds the next access in its
// output cycle. A store to a full table first drops its EVICT least recent
// entries, or empties it if it holds fewer than EVICT.
`default_nettype none

module pair_keyed_lru_cache import pklc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pklc_req_if.sink   i_req,
    pklc_rsp_if.source o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pklc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    pklc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_command   (i_req.command),
        .i_self_id   (i_req.self_id),
        .i_other_id  (i_req.other_id),
        .i_axis_x    (i_req.axis_x),
        .i_axis_y    (i_req.axis_y),
        .i_axis_z    (i_req.axis_z),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_found     (o_rsp.found),
        .o_hit_axis_x(o_rsp.hit_axis_x),
        .o_hit_axis_y(o_rsp.hit_axis_y),
        .o_hit_axis_z(o_rsp.hit_axis_z)
    );

endmodule

`default_nettype wire
